// ----- src/prcbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcbs_pkg: shared definitions for the per-rank clock barrier sync block
// Types and constants used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package prcbs_pkg;
	localparam int NUM_RANKS = 16;
	localparam int RANK_W = 4;
	localparam int WS_W = 5;
	localparam int TIME_W = 63;
	localparam int CNT_W = 32;
	localparam int DUR_W = 32;
	localparam int MASK_W = 16;
	localparam int UTIL_W = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic CMD_PROCESS = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [3:0] KIND_COMPUTE = 4'd0;
	localparam logic [3:0] KIND_COLL_LO = 4'd1;
	localparam logic [3:0] KIND_COLL_HI = 4'd6;
	localparam logic [3:0] KIND_COMM_HI = 4'd9;

	typedef struct packed {
		logic bad_rank;
		logic query;
		logic do_sync;
		logic is_compute;
		logic is_comm;
		logic [RANK_W-1:0] rank;
		logic [NUM_RANKS-1:0] group;
		logic [DUR_W-1:0] duration;
	} job_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ----- src/prcbs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcbs_front: request classifier
// Decodes a request into a job with its effective participant set.
// ----------------------------------------------------------------------------
module prcbs_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           command,
	input  wire logic [prcbs_pkg::RANK_W-1:0]   rank,
	input  wire logic [3:0]                     kind,
	input  wire logic [prcbs_pkg::MASK_W-1:0]   group_mask,
	input  wire logic [prcbs_pkg::DUR_W-1:0]    duration,
	input  wire logic [prcbs_pkg::WS_W-1:0]     rank_limit,
	output logic                                job_valid,
	input  wire logic                           job_ready,
	output prcbs_pkg::job_t                     job
);
	logic [prcbs_pkg::WS_W-1:0] act;
	logic [prcbs_pkg::NUM_RANKS-1:0] active_m;
	prcbs_pkg::job_t next_job;
	logic full_q;
	prcbs_pkg::job_t job_q;

	always_comb begin
		act = (rank_limit > prcbs_pkg::WS_W'(prcbs_pkg::NUM_RANKS)) ?
			prcbs_pkg::WS_W'(prcbs_pkg::NUM_RANKS) : rank_limit;
		for (int i = 0; i < prcbs_pkg::NUM_RANKS; i++)
			active_m[i] = prcbs_pkg::WS_W'(i) < act;
		next_job.bad_rank = {1'b0, rank} >= act;
		next_job.query = command == prcbs_pkg::CMD_QUERY;
		next_job.do_sync = kind inside {[prcbs_pkg::KIND_COLL_LO:prcbs_pkg::KIND_COLL_HI]};
		next_job.is_compute = kind == prcbs_pkg::KIND_COMPUTE;
		next_job.is_comm = kind inside {[prcbs_pkg::KIND_COLL_LO:prcbs_pkg::KIND_COMM_HI]};
		next_job.rank = rank;
		next_job.group = (group_mask == '0) ? active_m : (group_mask & active_m);
		next_job.duration = duration;
	end

	assign in_stall = full_q && !job_ready;
	assign job_valid = full_q;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			full_q <= 1'b1;
		end else if (job_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			job_q <= next_job;
		end
	end
endmodule
`default_nettype wire

// ----- src/prcbs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcbs_queue: job queue
// A two-entry queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module prcbs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_valid,
	output logic                 wr_ready,
	input  wire prcbs_pkg::job_t wr_job,
	output logic                 rd_valid,
	input  wire logic            rd_ready,
	output prcbs_pkg::job_t      rd_job
);
	prcbs_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end
endmodule
`default_nettype wire

// ----- src/prcbs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prcbs_back: job executor
// Synchronizes the group, advances the rank and builds the result.
// ----------------------------------------------------------------------------
module prcbs_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [prcbs_pkg::WS_W-1:0]     rank_limit,
	input  wire logic                           job_valid,
	output logic                                job_ready,
	input  wire prcbs_pkg::job_t                job,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                status,
	output logic [prcbs_pkg::RANK_W-1:0]        rank_out,
	output logic [prcbs_pkg::TIME_W-1:0]        clock_before,
	output logic [prcbs_pkg::TIME_W-1:0]        clock_after,
	output logic [prcbs_pkg::CNT_W-1:0]         event_count,
	output logic [prcbs_pkg::TIME_W-1:0]        compute_total,
	output logic [prcbs_pkg::TIME_W-1:0]        comm_total,
	output logic [prcbs_pkg::TIME_W-1:0]        blocked_total,
	output logic [prcbs_pkg::UTIL_W-1:0]        utilization,
	output logic [prcbs_pkg::TIME_W-1:0]        overall_time
);
	localparam int TW = prcbs_pkg::TIME_W;
	localparam int RW = prcbs_pkg::RANK_W;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAX = 3'd1;
	localparam logic [2:0] ST_SYNC = 3'd2;
	localparam logic [2:0] ST_EXEC = 3'd3;
	localparam logic [2:0] ST_OVR = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [TW-1:0] clk_q [prcbs_pkg::NUM_RANKS];
	logic [prcbs_pkg::CNT_W-1:0] ev_q [prcbs_pkg::NUM_RANKS];
	logic [TW-1:0] cmp_q [prcbs_pkg::NUM_RANKS];
	logic [TW-1:0] com_q [prcbs_pkg::NUM_RANKS];
	logic [TW-1:0] wt_q [prcbs_pkg::NUM_RANKS];

	logic [2:0] state_q;
	logic [RW:0] idx_q;
	prcbs_pkg::job_t job_q;
	logic [TW-1:0] top_q, start_q, ovr_q;
	logic [TW:0] rem_q;
	logic [prcbs_pkg::UTIL_W-1:0] quo_q;
	logic [4:0] dcnt_q;
	logic [prcbs_pkg::WS_W-1:0] act;
	logic [RW-1:0] ix, jr;
	logic [TW-1:0] cur, rc;
	logic [TW:0] rem2;

	assign act = (rank_limit > prcbs_pkg::WS_W'(prcbs_pkg::NUM_RANKS)) ?
		prcbs_pkg::WS_W'(prcbs_pkg::NUM_RANKS) : rank_limit;
	assign ix = idx_q[RW-1:0];
	assign jr = job_q.rank;
	assign cur = clk_q[ix];
	assign rc = clk_q[jr];
	assign rem2 = {rem_q[TW-1:0], 1'b0};
	assign job_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			for (int i = 0; i < prcbs_pkg::NUM_RANKS; i++) begin
				clk_q[i] <= '0;
				ev_q[i] <= '0;
				cmp_q[i] <= '0;
				com_q[i] <= '0;
				wt_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						idx_q <= '0;
						state_q <= (!job.bad_rank && !job.query && job.do_sync) ?
							ST_MAX : ST_EXEC;
					end
				end
				ST_MAX: begin
					if (idx_q == (RW+1)'(prcbs_pkg::NUM_RANKS - 1)) begin
						idx_q <= '0;
						state_q <= ST_SYNC;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SYNC: begin
					if (job_q.group[ix] && cur < top_q) begin
						wt_q[ix] <= prcbs_pkg::sat_add(wt_q[ix], top_q - cur);
						clk_q[ix] <= top_q;
					end
					if (idx_q == (RW+1)'(prcbs_pkg::NUM_RANKS - 1)) begin
						state_q <= ST_EXEC;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EXEC: begin
					if (!job_q.bad_rank && !job_q.query) begin
						clk_q[jr] <= prcbs_pkg::sat_add(rc, TW'(job_q.duration));
						if (ev_q[jr] != prcbs_pkg::COUNT_MAX) ev_q[jr] <= ev_q[jr] + 1'b1;
						if (job_q.is_compute)
							cmp_q[jr] <= prcbs_pkg::sat_add(cmp_q[jr], TW'(job_q.duration));
						if (job_q.is_comm)
							com_q[jr] <= prcbs_pkg::sat_add(com_q[jr], TW'(job_q.duration));
					end
					idx_q <= '0;
					state_q <= ST_OVR;
				end
				ST_OVR: begin
					if (idx_q == (RW+1)'(prcbs_pkg::NUM_RANKS - 1)) begin
						state_q <= ST_DIV;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (dcnt_q == 5'd16) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= job;
				top_q <= '0;
				ovr_q <= '0;
			end
			ST_MAX: begin
				if (job_q.group[ix] && cur > top_q) top_q <= cur;
			end
			ST_EXEC: begin
				start_q <= rc;
				ovr_q <= '0;
			end
			ST_OVR: begin
				if ({1'b0, ix} < act && cur > ovr_q) ovr_q <= cur;
				rem_q <= {1'b0, cmp_q[jr]};
				quo_q <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				if (dcnt_q != 5'd16) begin
					dcnt_q <= dcnt_q + 1'b1;
					if (rem2 >= {1'b0, rc}) begin
						rem_q <= rem2 - {1'b0, rc};
						quo_q <= {quo_q[prcbs_pkg::UTIL_W-2:0], 1'b1};
					end else begin
						rem_q <= rem2;
						quo_q <= {quo_q[prcbs_pkg::UTIL_W-2:0], 1'b0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status = job_q.bad_rank;
		rank_out = job_q.rank;
		overall_time = ovr_q;
		if (job_q.bad_rank) begin
			clock_before = '0;
			clock_after = '0;
			event_count = '0;
			compute_total = '0;
			comm_total = '0;
			blocked_total = '0;
			utilization = '0;
		end else begin
			clock_before = job_q.query ? rc : start_q;
			clock_after = rc;
			event_count = ev_q[jr];
			compute_total = cmp_q[jr];
			comm_total = com_q[jr];
			blocked_total = wt_q[jr];
			if (rc == '0) utilization = '0;
			else if (cmp_q[jr] >= rc) utilization = '1;
			else utilization = quo_q;
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> !out_valid) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(rank_out))
		else $error("result changed while stalled");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && $past(state_q) == ST_DIV |-> dcnt_q == 5'd16)
		else $error("division cut short");
`endif
endmodule
`default_nettype wire

// ----- src/per_rank_clock_barrier_sync.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_rank_clock_barrier_sync: per-rank clocks with collective barriers
// Keeps per-rank clocks and totals, synchronizes groups, reports metrics.
// ----------------------------------------------------------------------------
// Each request passes the classifier register and the two-entry queue before
// the executor takes it. One request is executed at a time, so the executor
// sets the rate; the front end and the queue can take new requests meanwhile.
// A collective request runs a max pass and a sync pass, and every request an
// overall-time pass, each over the clocks of all sixteen ranks, and a sixteen-step division.
// Asynchronous reset clears all clocks and totals and sets world size to 16.
module per_rank_clock_barrier_sync (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           command,
	input  wire logic [prcbs_pkg::RANK_W-1:0]   rank,
	input  wire logic [3:0]                     kind,
	input  wire logic [prcbs_pkg::MASK_W-1:0]   group_mask,
	input  wire logic [prcbs_pkg::DUR_W-1:0]    duration,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [prcbs_pkg::WS_W-1:0]     cfg_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                status,
	output logic [prcbs_pkg::RANK_W-1:0]        rank_out,
	output logic [prcbs_pkg::TIME_W-1:0]        clock_before,
	output logic [prcbs_pkg::TIME_W-1:0]        clock_after,
	output logic [prcbs_pkg::CNT_W-1:0]         event_count,
	output logic [prcbs_pkg::TIME_W-1:0]        compute_total,
	output logic [prcbs_pkg::TIME_W-1:0]        comm_total,
	output logic [prcbs_pkg::TIME_W-1:0]        blocked_total,
	output logic [prcbs_pkg::UTIL_W-1:0]        utilization,
	output logic [prcbs_pkg::TIME_W-1:0]        overall_time
);
	logic [prcbs_pkg::WS_W-1:0] ws_q;
	logic f_valid, f_ready, b_valid, b_ready;
	prcbs_pkg::job_t f_job, b_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= prcbs_pkg::WS_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			ws_q <= cfg_data;
		end
	end

	prcbs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .rank(rank), .kind(kind), .group_mask(group_mask),
		.duration(duration), .rank_limit(ws_q), .job_valid(f_valid),
		.job_ready(f_ready), .job(f_job)
	);

	prcbs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_job(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
	);

	prcbs_back u_back (
		.clk(clk), .arst_n(arst_n), .rank_limit(ws_q), .job_valid(b_valid),
		.job_ready(b_ready), .job(b_job), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .rank_out(rank_out),
		.clock_before(clock_before), .clock_after(clock_after),
		.event_count(event_count),
		.compute_total(compute_total), .comm_total(comm_total),
		.blocked_total(blocked_total), .utilization(utilization),
		.overall_time(overall_time)
	);
endmodule
`default_nettype wire
